### hdl/spm_pkg.sv
`timescale 1ns / 1ps

package spm_pkg;

  // store geometry
  localparam int MAX_LEN = 1024;
  localparam int IDX_W   = $clog2(MAX_LEN);
  localparam int LEN_W   = IDX_W + 1;

  // fixed field widths
  localparam int CFG_W = 11;
  localparam int VAL_W = 32;
  localparam int RES_W = 33;

  // request action codes
  localparam logic [1:0] ACT_WRITE_FIRST  = 2'd0;
  localparam logic [1:0] ACT_WRITE_SECOND = 2'd1;
  localparam logic [1:0] ACT_COMPUTE      = 2'd2;

  // microprogram addresses
  localparam int PC_W = 3;
  localparam logic [PC_W-1:0] PC_WAIT     = 3'd0;
  localparam logic [PC_W-1:0] PC_SPLIT    = 3'd1;
  localparam logic [PC_W-1:0] PC_ODD_RD   = 3'd2;
  localparam logic [PC_W-1:0] PC_ODD_CMP  = 3'd3;
  localparam logic [PC_W-1:0] PC_EVEN_LO  = 3'd4;
  localparam logic [PC_W-1:0] PC_EVEN_HI  = 3'd5;
  localparam logic [PC_W-1:0] PC_EVEN_SUM = 3'd6;
  localparam logic [PC_W-1:0] PC_EVEN_CMP = 3'd7;

  // store read address select
  typedef enum logic [1:0] {
    RD_NONE,
    RD_MID_LO,
    RD_MID
  } rd_sel_t;

  // datapath operation
  typedef enum logic [2:0] {
    OP_NONE,
    OP_INIT,
    OP_LATCH_LO,
    OP_SUM,
    OP_EVEN_CMP,
    OP_ODD_CMP
  } dp_op_t;

  // jump condition
  typedef enum logic [1:0] {
    C_NEVER,
    C_START,
    C_ODD,
    C_FINISH
  } cond_t;

  // one microcode word
  typedef struct packed {
    rd_sel_t         rd_sel;
    dp_op_t          op;
    cond_t           cond;
    logic [PC_W-1:0] jump_to;
    logic [PC_W-1:0] next_to;
  } ctrl_t;

  // datapath flags back to the sequencer
  typedef struct packed {
    logic len_odd;
    logic finish;
  } status_t;

endpackage

### hdl/spm_store.sv
`timescale 1ns / 1ps

module spm_store (
  input  logic                      clk,
  input  logic                      en,
  input  logic                      we,
  input  logic [spm_pkg::IDX_W-1:0] addr,
  input  logic [spm_pkg::VAL_W-1:0] wdata,
  output logic [spm_pkg::VAL_W-1:0] rdata
);

  logic [spm_pkg::VAL_W-1:0] mem [spm_pkg::MAX_LEN];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

### hdl/spm_rom.sv
`timescale 1ns / 1ps

module spm_rom (
  input  logic [spm_pkg::PC_W-1:0] pc,
  output spm_pkg::ctrl_t           ctrl
);

  // control store: read select, op, condition, taken target, fall-through target
  always_comb begin
    case (pc)
      spm_pkg::PC_WAIT: ctrl = '{spm_pkg::RD_NONE, spm_pkg::OP_INIT, spm_pkg::C_START,
                                 spm_pkg::PC_SPLIT, spm_pkg::PC_WAIT};
      spm_pkg::PC_SPLIT: ctrl = '{spm_pkg::RD_NONE, spm_pkg::OP_NONE, spm_pkg::C_ODD,
                                  spm_pkg::PC_ODD_RD, spm_pkg::PC_EVEN_LO};
      spm_pkg::PC_ODD_RD: ctrl = '{spm_pkg::RD_MID, spm_pkg::OP_NONE, spm_pkg::C_NEVER,
                                   spm_pkg::PC_ODD_CMP, spm_pkg::PC_ODD_CMP};
      spm_pkg::PC_ODD_CMP: ctrl = '{spm_pkg::RD_NONE, spm_pkg::OP_ODD_CMP, spm_pkg::C_FINISH,
                                    spm_pkg::PC_WAIT, spm_pkg::PC_SPLIT};
      spm_pkg::PC_EVEN_LO: ctrl = '{spm_pkg::RD_MID_LO, spm_pkg::OP_NONE, spm_pkg::C_NEVER,
                                    spm_pkg::PC_EVEN_HI, spm_pkg::PC_EVEN_HI};
      spm_pkg::PC_EVEN_HI: ctrl = '{spm_pkg::RD_MID, spm_pkg::OP_LATCH_LO, spm_pkg::C_NEVER,
                                    spm_pkg::PC_EVEN_SUM, spm_pkg::PC_EVEN_SUM};
      spm_pkg::PC_EVEN_SUM: ctrl = '{spm_pkg::RD_NONE, spm_pkg::OP_SUM, spm_pkg::C_NEVER,
                                     spm_pkg::PC_EVEN_CMP, spm_pkg::PC_EVEN_CMP};
      spm_pkg::PC_EVEN_CMP: ctrl = '{spm_pkg::RD_NONE, spm_pkg::OP_EVEN_CMP, spm_pkg::C_FINISH,
                                     spm_pkg::PC_WAIT, spm_pkg::PC_SPLIT};
      default: ctrl = '{spm_pkg::RD_NONE, spm_pkg::OP_NONE, spm_pkg::C_NEVER,
                        spm_pkg::PC_WAIT, spm_pkg::PC_WAIT};
    endcase
  end

endmodule

### hdl/spm_datapath.sv
`timescale 1ns / 1ps

module spm_datapath (
  input  logic                             clk,
  input  spm_pkg::ctrl_t                   ctrl,
  input  logic                             start,
  input  logic                             wr_first,
  input  logic                             wr_second,
  input  logic [spm_pkg::IDX_W-1:0]        wr_index,
  input  logic [spm_pkg::VAL_W-1:0]        wr_value,
  input  logic [spm_pkg::CFG_W-1:0]        array_length,
  output spm_pkg::status_t                 status,
  output logic signed [spm_pkg::RES_W-1:0] result
);

  localparam int IDX_W = spm_pkg::IDX_W;
  localparam int LEN_W = spm_pkg::LEN_W;
  localparam int VAL_W = spm_pkg::VAL_W;
  localparam int RES_W = spm_pkg::RES_W;

  // search windows, equal length on both sides
  logic [IDX_W-1:0] la, ra, lb, rb;
  logic signed [VAL_W-1:0] a_lo, b_lo;
  logic signed [RES_W-1:0] sa, sb;

  logic [VAL_W-1:0] rdata_a, rdata_b;
  logic signed [VAL_W-1:0] a_rd, b_rd;
  logic [LEN_W-1:0] len;
  logic [IDX_W-1:0] h;
  logic [IDX_W-1:0] mid_a, mid_b, rd_addr_a, rd_addr_b, addr_a, addr_b;
  logic [LEN_W-1:0] n_eff;
  logic [IDX_W-1:0] last;
  logic rd_en;
  logic len_one, len_two;
  logic eq_odd, lt_odd, eq_even, lt_even;

  assign a_rd = $signed(rdata_a);
  assign b_rd = $signed(rdata_b);

  // effective length: zero acts as one, large values saturate
  always_comb begin
    if (array_length == '0) begin
      n_eff = LEN_W'(1);
    end else if (32'(array_length) > 32'(spm_pkg::MAX_LEN)) begin
      n_eff = LEN_W'(spm_pkg::MAX_LEN);
    end else begin
      n_eff = LEN_W'(array_length);
    end
  end
  assign last = IDX_W'(n_eff - LEN_W'(1));

  // window length and midpoints
  assign len   = {1'b0, ra} - {1'b0, la} + LEN_W'(1);
  assign h     = len[LEN_W-1:1];
  assign mid_a = la + h;
  assign mid_b = lb + h;

  always_comb begin
    if (ctrl.rd_sel == spm_pkg::RD_MID_LO) begin
      rd_addr_a = mid_a - IDX_W'(1);
      rd_addr_b = mid_b - IDX_W'(1);
    end else begin
      rd_addr_a = mid_a;
      rd_addr_b = mid_b;
    end
  end

  // store port sharing: writes while waiting, reads during the search
  assign rd_en  = (ctrl.rd_sel != spm_pkg::RD_NONE);
  assign addr_a = wr_first  ? wr_index : rd_addr_a;
  assign addr_b = wr_second ? wr_index : rd_addr_b;

  spm_store u_first (
    .clk   (clk),
    .en    (wr_first | rd_en),
    .we    (wr_first),
    .addr  (addr_a),
    .wdata (wr_value),
    .rdata (rdata_a)
  );

  spm_store u_second (
    .clk   (clk),
    .en    (wr_second | rd_en),
    .we    (wr_second),
    .addr  (addr_b),
    .wdata (wr_value),
    .rdata (rdata_b)
  );

  // compares
  assign len_one = (len == LEN_W'(1));
  assign len_two = (len == LEN_W'(2));
  assign eq_odd  = (a_rd == b_rd);
  assign lt_odd  = (a_rd < b_rd);
  assign eq_even = (sa == sb);
  assign lt_even = (sa < sb);

  // status and result
  always_comb begin
    status.len_odd = len[0];
    status.finish  = 1'b0;
    result         = sa;
    case (ctrl.op)
      spm_pkg::OP_ODD_CMP: begin
        status.finish = len_one | eq_odd;
        if (len_one) begin
          result = RES_W'(a_rd) + RES_W'(b_rd);
        end else begin
          result = {a_rd, 1'b0};
        end
      end
      spm_pkg::OP_EVEN_CMP: begin
        status.finish = len_two | eq_even;
        if (len_two) begin
          result = sa + sb;
        end else begin
          result = sa;
        end
      end
      default: begin
        status.finish = 1'b0;
      end
    endcase
  end

  // window and operand registers
  always_ff @(posedge clk) begin
    case (ctrl.op)
      spm_pkg::OP_INIT: begin
        if (start) begin
          la <= '0;
          lb <= '0;
          ra <= last;
          rb <= last;
        end
      end
      spm_pkg::OP_LATCH_LO: begin
        a_lo <= a_rd;
        b_lo <= b_rd;
      end
      spm_pkg::OP_SUM: begin
        if (len_two) begin
          sa <= (a_lo > b_lo) ? RES_W'(a_lo) : RES_W'(b_lo);
          sb <= (a_rd < b_rd) ? RES_W'(a_rd) : RES_W'(b_rd);
        end else begin
          sa <= RES_W'(a_lo) + RES_W'(a_rd);
          sb <= RES_W'(b_lo) + RES_W'(b_rd);
        end
      end
      spm_pkg::OP_ODD_CMP: begin
        if (!status.finish) begin
          if (lt_odd) begin
            la <= mid_a;
            rb <= rb - h;
          end else begin
            lb <= mid_b;
            ra <= ra - h;
          end
        end
      end
      spm_pkg::OP_EVEN_CMP: begin
        if (!status.finish) begin
          if (lt_even) begin
            la <= mid_a - IDX_W'(1);
            rb <= rb - h + IDX_W'(1);
          end else begin
            lb <= mid_b - IDX_W'(1);
            ra <= ra - h + IDX_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### hdl/sorted_pair_median_unit.sv
`timescale 1ns / 1ps

// channel   direction  handshake             payload
// in        input      in_valid / in_stall   action, element_index, element_value
// out       output     out_valid / out_stall median_halves
// cfg       input      cfg_valid / cfg_ready cfg_data (array_length)
//
// a store write is taken at the wait step; a compute holds the input through the split
// step, then per odd-length window step a read and a compare step, per even-length one
// low read, high read, sum and compare steps; the result is registered at the last step
// rst is synchronous: sequencer back at its wait step, output empty, length one
// requests stall while a compute runs or while the result register is held
// stores have no reset; entries read before being written give undefined sums

module sorted_pair_median_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       action,
  input  logic [spm_pkg::IDX_W-1:0]        element_index,
  input  logic signed [spm_pkg::VAL_W-1:0] element_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [spm_pkg::RES_W-1:0] median_halves,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [spm_pkg::CFG_W-1:0]        cfg_data
);

  logic [spm_pkg::PC_W-1:0] pc, pc_next;
  spm_pkg::ctrl_t ctrl;
  spm_pkg::status_t status;
  logic signed [spm_pkg::RES_W-1:0] result;
  logic [spm_pkg::CFG_W-1:0] array_length;
  logic in_accept, start, wr_first, wr_second, taken;

  // request handshake
  assign in_stall  = (pc != spm_pkg::PC_WAIT) | (out_valid & out_stall);
  assign in_accept = in_valid & ~in_stall;
  assign start     = in_accept & (action == spm_pkg::ACT_COMPUTE);
  assign wr_first  = in_accept & (action == spm_pkg::ACT_WRITE_FIRST);
  assign wr_second = in_accept & (action == spm_pkg::ACT_WRITE_SECOND);

  // length register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      array_length <= spm_pkg::CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      array_length <= cfg_data;
    end
  end

  spm_rom u_rom (
    .pc   (pc),
    .ctrl (ctrl)
  );

  spm_datapath u_dp (
    .clk          (clk),
    .ctrl         (ctrl),
    .start        (start),
    .wr_first     (wr_first),
    .wr_second    (wr_second),
    .wr_index     (element_index),
    .wr_value     (element_value),
    .array_length (array_length),
    .status       (status),
    .result       (result)
  );

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= spm_pkg::PC_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  // jump condition and next step
  always_comb begin
    case (ctrl.cond)
      spm_pkg::C_START:  taken = start;
      spm_pkg::C_ODD:    taken = status.len_odd;
      spm_pkg::C_FINISH: taken = status.finish;
      default:           taken = 1'b0;
    endcase
    pc_next = taken ? ctrl.jump_to : ctrl.next_to;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= status.finish | (out_valid & out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (status.finish) begin
      median_halves <= result;
    end
  end

`ifndef SYNTHESIS
  // a finished search never overwrites a result still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    status.finish |-> !(out_valid && out_stall))
    else $error("result register overwritten while held");

  // a compute request starts the search at the split step
  a_start_split: assert property (@(posedge clk) disable iff (rst)
    start |=> (pc == spm_pkg::PC_SPLIT))
    else $error("compute request did not start the search");

  // store writes happen only from the wait step
  a_write_wait: assert property (@(posedge clk) disable iff (rst)
    (wr_first || wr_second) |-> (pc == spm_pkg::PC_WAIT) && (ctrl.rd_sel == spm_pkg::RD_NONE))
    else $error("store write during search");

  // a result appears only after a search step that finishes
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(pc) == spm_pkg::PC_ODD_CMP || $past(pc) == spm_pkg::PC_EVEN_CMP))
    else $error("result without a finishing compare");
`endif

endmodule
